// ===== rtl/core/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg - shared types and constants of the command frame builder
// Request and response formats, job descriptor passed from the front end
// to the byte emitter, frame constants.
// ----------------------------------------------------------------------------
package cfb_pkg;

   // request commands
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // frame constants
   localparam logic [7:0] HDR_BYTE     = 8'hAA;
   localparam logic [7:0] TAIL_BYTE    = 8'hDD;
   localparam logic [7:0] LEN_OVERHEAD = 8'd3;
   localparam logic [7:0] MAX_PAYLOAD  = 8'd252;

   // job queue between front end and emitter
   localparam int JOB_QUEUE_DEPTH = 4;
   localparam int JOB_PTR_WIDTH   = $clog2(JOB_QUEUE_DEPTH);
   localparam int JOB_CNT_WIDTH   = $clog2(JOB_QUEUE_DEPTH + 1);

   // byte positions within a frame, as walked by the emitter
   localparam logic [2:0] POS_HDR     = 3'd0;
   localparam logic [2:0] POS_LEN     = 3'd1;
   localparam logic [2:0] POS_OPCODE  = 3'd2;
   localparam logic [2:0] POS_ADDR_LO = 3'd3;
   localparam logic [2:0] POS_BODY    = 3'd4;   // address high byte or payload byte
   localparam logic [2:0] POS_SUM_LO  = 3'd5;
   localparam logic [2:0] POS_SUM_HI  = 3'd6;
   localparam logic [2:0] POS_TAIL    = 3'd7;

   typedef struct packed {
      logic        command;
      logic [7:0]  opcode;
      logic [15:0] station_address;
      logic [7:0]  payload_count;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_ERROR  = 2'd0,
      JOB_HEADER = 2'd1,
      JOB_DATA   = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         trailer;      // close the frame after this job's bytes
      logic [7:0]   length;
      logic [7:0]   opcode;
      logic [15:0]  address;
      logic [7:0]   data;
      logic [15:0]  sum;          // checksum to send if trailer is set
   } job_type;

endpackage

// ===== rtl/core/cfb_front.sv =====
// ----------------------------------------------------------------------------
// cfb_front - request classifier and frame state
// Accepts requests, checks the frame phase, keeps the running checksum and
// turns every request into one job descriptor for the emitter.
// ----------------------------------------------------------------------------
module cfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  cfb_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             req_full,
   output logic             job_push,
   output cfb_pkg::job_type job_data
);
   import cfb_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;

   logic        accept;
   logic [7:0]  count_sat;
   logic [15:0] head_sum;
   logic [15:0] data_sum;
   logic        last_byte;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;
   assign job_push = accept;

   // clamp the count and precompute both checksum updates
   assign count_sat = (req_data.payload_count > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                             : req_data.payload_count;
   assign head_sum  = 16'(req_data.opcode) + 16'(req_data.station_address[7:0])
                    + 16'(req_data.station_address[15:8]);
   assign data_sum  = sum_ff + 16'(req_data.payload_byte);
   assign last_byte = (remaining_ff == 8'd1);

   // classify the request and build its job
   always_comb begin
      frame_open_in    = frame_open_ff;
      remaining_in     = remaining_ff;
      sum_in           = sum_ff;
      job_data         = '0;
      job_data.kind    = JOB_ERROR;
      job_data.opcode  = req_data.opcode;
      job_data.address = req_data.station_address;
      job_data.data    = req_data.payload_byte;
      job_data.length  = LEN_OVERHEAD + count_sat;
      if (req_data.command == CMD_START) begin
         if (!frame_open_ff) begin
            job_data.kind    = JOB_HEADER;
            job_data.trailer = (count_sat == 8'd0);
            job_data.sum     = head_sum;
            if (accept) begin
               frame_open_in = (count_sat != 8'd0);
               remaining_in  = count_sat;
               sum_in        = (count_sat == 8'd0) ? 16'd0 : head_sum;
            end
         end
      end else begin
         if (frame_open_ff) begin
            job_data.kind    = JOB_DATA;
            job_data.trailer = last_byte;
            job_data.sum     = data_sum;
            if (accept) begin
               frame_open_in = !last_byte;
               remaining_in  = remaining_ff - 8'd1;
               sum_in        = last_byte ? 16'd0 : data_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= '0;
         sum_ff        <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

// ===== rtl/core/cfb_queue.sv =====
// ----------------------------------------------------------------------------
// cfb_queue - job queue
// Small register FIFO of job descriptors that decouples the front end from
// the byte emitter and soaks up header and trailer bursts.
// ----------------------------------------------------------------------------
module cfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfb_pkg::job_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output cfb_pkg::job_type head
);
   import cfb_pkg::*;

   job_type                  slot_ff [JOB_QUEUE_DEPTH];
   logic [JOB_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == JOB_CNT_WIDTH'(JOB_QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_WIDTH'(JOB_QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_WIDTH'(JOB_QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/cfb_back.sv =====
// ----------------------------------------------------------------------------
// cfb_back - byte emitter
// Walks the head job of the queue one wire byte per cycle while the consumer
// pops, holding each byte in an output register until the consumer pops it.
// ----------------------------------------------------------------------------
module cfb_back (
   input  logic             clock,
   input  logic             reset,
   input  cfb_pkg::job_type head,
   input  logic             head_empty,
   output logic             head_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cfb_pkg::rsp_type rsp_data
);
   import cfb_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic       advance;
   logic [2:0] pos;
   logic       last;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign advance   = !head_empty && (!out_valid_ff || rsp_pop);

   // position within the frame and end of this job
   always_comb begin
      pos  = ((head.kind == JOB_DATA) ? POS_BODY : POS_HDR) + step_ff;
      last = (head.kind == JOB_ERROR) ||
             (head.trailer ? (pos == POS_TAIL) : (pos == POS_BODY));
   end

   assign head_pop = advance && last;

   // select the byte for this position
   always_comb begin
      out_in           = '0;
      out_in.frame_end = 1'b0;
      if (head.kind == JOB_ERROR) begin
         out_in.error = 1'b1;
      end else begin
         case (pos)
            POS_HDR:     out_in.tx_byte = HDR_BYTE;
            POS_LEN:     out_in.tx_byte = head.length;
            POS_OPCODE:  out_in.tx_byte = head.opcode;
            POS_ADDR_LO: out_in.tx_byte = head.address[7:0];
            POS_BODY:    out_in.tx_byte = (head.kind == JOB_DATA) ? head.data
                                                                  : head.address[15:8];
            POS_SUM_LO:  out_in.tx_byte = head.sum[7:0];
            POS_SUM_HI:  out_in.tx_byte = head.sum[15:8];
            POS_TAIL: begin
               out_in.tx_byte   = TAIL_BYTE;
               out_in.frame_end = 1'b1;
            end
            default:     out_in.tx_byte = '0;
         endcase
      end
   end

   // advance the step and the output register
   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         step_in      = last ? 3'd0 : step_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/core/command_frame_builder_sum_check_top.sv =====
// ----------------------------------------------------------------------------
// command_frame_builder_sum_check_top - command frame builder with sum check
// Turns start and payload requests into framed wire bytes with a 16-bit
// additive checksum and a tail byte.
// ----------------------------------------------------------------------------
// A request is taken in any cycle in which the job queue (four entries) has
// room; the front end classifies it and updates the frame state in that same
// cycle. The emitter sends one wire byte per cycle while the receiver pops,
// so its output port sets the rate: a payload request is one byte (four when
// it closes the frame), a start request five (eight with a zero count), an
// out of phase request one error result. A request's first byte passes the
// job queue and the emitter's output register to the response port. Payload
// requests run at one per cycle while the receiver pops; the queue absorbs
// header and trailer bursts and pushes back through req_full when it fills.
module command_frame_builder_sum_check_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cfb_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cfb_pkg::rsp_type rsp_data
);
   import cfb_pkg::*;

   logic    job_push;
   job_type job_in;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_pop;
   job_type queue_head;

   cfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_full   (req_full),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   cfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   cfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .head_empty (queue_empty),
      .head_pop   (queue_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // the emitter never retires a job that is not there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("job queue popped while empty");

   // a frame end response always carries the tail byte
   a_tail_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |-> (rsp_data.tx_byte == TAIL_BYTE && !rsp_data.error))
      else $error("frame end without tail byte");

   // an error response carries a zero byte and never closes a frame
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.error) |-> (rsp_data.tx_byte == 8'd0 && !rsp_data.frame_end))
      else $error("error response with data");

   // a job the front end pushes shows up in the queue the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      job_push |=> !queue_empty)
      else $error("pushed job missing from queue");

endmodule

// ===== sim/command_frame_builder_sum_check_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_builder_sum_check_top_test - frame builder testbench
// Drives start and payload requests into the frame builder, predicts every
// wire byte of each frame (header, length, opcode, address, payload,
// checksum, tail) and phase error results, and checks the response stream
// in order under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module command_frame_builder_sum_check_top_test;
   import cfb_pkg::*;

   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES    = 16;
   localparam int RANDOM_ITEMS     = 12;
   localparam int HOLD_PAYLOADS    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // frame state as the builder should hold it
   logic        frame_is_open = 1'b0;
   logic [7:0]  payload_left = 8'd0;
   logic [15:0] frame_sum = 16'd0;

   rsp_type expected_wire_bytes[$];

   int  error_count = 0;
   int  requests_sent = 0;
   int  bytes_checked = 0;
   int  frames_closed = 0;
   int  phase_errors_seen = 0;
   int  full_stall_cycles = 0;
   int  burst_left = 0;
   bit  idle_enable = 1'b1;
   int  hold_off_req = 0;
   logic hold_active = 1'b0;

   command_frame_builder_sum_check_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void queue_wire_byte(input logic [7:0] value, input logic is_end,
                                           input logic is_error);
      rsp_type entry;
      entry.tx_byte   = value;
      entry.frame_end = is_end;
      entry.error     = is_error;
      expected_wire_bytes.push_back(entry);
   endfunction

   // close the frame: checksum low, high, then tail
   function automatic void queue_trailer();
      queue_wire_byte(frame_sum[7:0], 1'b0, 1'b0);
      queue_wire_byte(frame_sum[15:8], 1'b0, 1'b0);
      queue_wire_byte(TAIL_BYTE, 1'b1, 1'b0);
      frame_is_open = 1'b0;
      payload_left  = 8'd0;
      frame_sum     = 16'd0;
   endfunction

   function automatic void predict_wire_bytes(input req_type item);
      logic [7:0] count;
      if (item.command == CMD_START) begin
         // a start inside an open frame is refused, frame goes on
         if (frame_is_open) begin
            queue_wire_byte(8'h00, 1'b0, 1'b1);
            return;
         end
         count = (item.payload_count > MAX_PAYLOAD) ? MAX_PAYLOAD : item.payload_count;
         frame_sum = 16'(item.opcode) + 16'(item.station_address[7:0])
                     + 16'(item.station_address[15:8]);
         queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
         queue_wire_byte(LEN_OVERHEAD + count, 1'b0, 1'b0);
         queue_wire_byte(item.opcode, 1'b0, 1'b0);
         queue_wire_byte(item.station_address[7:0], 1'b0, 1'b0);
         queue_wire_byte(item.station_address[15:8], 1'b0, 1'b0);
         if (count == 8'd0) begin
            queue_trailer();
         end else begin
            frame_is_open = 1'b1;
            payload_left  = count;
         end
      end else begin
         // payload outside a frame is refused
         if (!frame_is_open) begin
            queue_wire_byte(8'h00, 1'b0, 1'b1);
            return;
         end
         frame_sum = frame_sum + 16'(item.payload_byte);
         queue_wire_byte(item.payload_byte, 1'b0, 1'b0);
         payload_left = payload_left - 8'd1;
         if (payload_left == 8'd0) begin
            queue_trailer();
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request building and sending
   // ------------------------------------------------------------------------
   function automatic req_type make_start(input logic [7:0] op, input logic [15:0] addr,
                                          input logic [7:0] count);
      req_type item;
      item.command         = CMD_START;
      item.opcode          = op;
      item.station_address = addr;
      item.payload_count   = count;
      item.payload_byte    = 8'($urandom);
      return item;
   endfunction

   // unused fields of a payload request carry random junk
   function automatic req_type make_payload(input logic [7:0] value);
      req_type item;
      item.command         = CMD_PAYLOAD;
      item.opcode          = 8'($urandom);
      item.station_address = 16'($urandom);
      item.payload_count   = 8'($urandom);
      item.payload_byte    = value;
      return item;
   endfunction

   // offer one request, hold it until taken; push stays high afterwards
   task automatic send_request(input req_type item);
      int gap;
      if (idle_enable && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_wire_bytes(item);
      requests_sent++;
   endtask

   // drop push and wait until every predicted byte has come out
   task automatic wait_for_drain();
      req_push <= 1'b0;
      burst_left = 0;
      while (expected_wire_bytes.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_frames();
      // stray payload right after reset
      send_request(make_payload(8'hFF));
      // zero count frames at both field extremes
      send_request(make_start(8'h00, 16'h0000, 8'd0));
      send_request(make_start(8'hFF, 16'hFFFF, 8'd0));
      // single payload byte
      send_request(make_start(8'h5A, 16'hA55A, 8'd1));
      send_request(make_payload(8'hA5));
      // start inside an open frame, then finish the frame
      send_request(make_start(8'hC3, 16'h1234, 8'd3));
      send_request(make_start(8'hFF, 16'hFFFF, 8'hFF));
      send_request(make_payload(8'h00));
      send_request(make_payload(8'hFF));
      send_request(make_payload(8'h80));
      // payload after the frame closed
      send_request(make_payload(8'h7F));
      send_request(make_start(8'h81, 16'h8001, 8'd2));
      send_request(make_payload(8'h01));
      send_request(make_start(8'h00, 16'h0000, 8'd0));
      send_request(make_payload(8'hFE));
      send_request(make_payload(8'h5A));
   endtask

   // count above the maximum saturates; all-ones bytes give the largest sum
   task automatic test_longest_frame();
      send_request(make_start(8'hFF, 16'hFFFF, 8'hFF));
      for (int i = 0; i < int'(MAX_PAYLOAD); i++) begin
         send_request(make_payload(8'hFF));
      end
   endtask

   // receiver holds off while the sender keeps pushing, then full drain pause
   task automatic test_backpressure();
      wait_for_drain();
      hold_off_req <= hold_off_req + 1;
      do @(posedge clock); while (!hold_active);
      idle_enable = 1'b0;
      send_request(make_start(8'h3C, 16'hBEEF, 8'(HOLD_PAYLOADS)));
      for (int i = 0; i < HOLD_PAYLOADS; i++) begin
         send_request(make_payload(8'($urandom)));
      end
      send_request(make_start(8'h11, 16'h2233, 8'd0));
      wait_for_drain();
      idle_enable = 1'b1;
   endtask

   // mostly well-formed frames with random content, some stray requests
   task automatic test_random_traffic();
      int         good_items;
      logic [7:0] count;
      bit         stray;
      req_type    item;
      good_items = 0;
      while (good_items < RANDOM_ITEMS) begin
         if (frame_is_open) begin
            stray = ($urandom_range(0, 99) < 8);
            if (stray) begin
               item = make_start(8'($urandom), 16'($urandom), 8'($urandom));
            end else begin
               item = make_payload(8'($urandom));
            end
         end else begin
            stray = ($urandom_range(0, 99) < 12);
            if (stray) begin
               item = make_payload(8'($urandom));
            end else begin
               count = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(9, 60))
                                                    : 8'($urandom_range(0, 6));
               item = make_start(8'($urandom), 16'($urandom), count);
            end
         end
         send_request(item);
         if (!stray) good_items++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: changing pop patterns, one long hold-off per request
   // ------------------------------------------------------------------------
   initial begin : pop_pattern
      int mode;
      int span;
      int hold_done;
      hold_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req != hold_done) begin
            hold_done++;
            hold_active <= 1'b1;
            rsp_pop     <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 30);
            repeat (span) begin
               case (mode)
                  0: rsp_pop <= 1'b1;
                  1: rsp_pop <= 1'($urandom_range(0, 1));
                  2: rsp_pop <= ($urandom_range(0, 4) != 0);
                  default: rsp_pop <= ($urandom_range(0, 5) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Compare each popped byte with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_wire_bytes
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_wire_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual tx_byte=%02h end=%0b err=%0b",
                     $time, rsp_data.tx_byte, rsp_data.frame_end, rsp_data.error);
            error_count++;
         end else begin
            want = expected_wire_bytes.pop_front();
            bytes_checked++;
            if (want.frame_end) frames_closed++;
            if (want.error) phase_errors_seen++;
            if (rsp_data.tx_byte !== want.tx_byte) begin
               $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                        $time, want.tx_byte, rsp_data.tx_byte);
               error_count++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                        $time, want.frame_end, rsp_data.frame_end);
               error_count++;
            end
            if (rsp_data.error !== want.error) begin
               $display("%0t: error mismatch: expected %0b, actual %0b",
                        $time, want.error, rsp_data.error);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : stall_watchdog
      int quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (!reset && req_push && req_full) full_stall_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or byte accepted for %0d cycles, %0d bytes outstanding",
                  $time, quiet_cycles, expected_wire_bytes.size());
         $display("** command_frame_builder_sum_check_top: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_longest_frame();
      test_backpressure();
      test_random_traffic();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests, checked %0d wire bytes in %0d frames, %0d phase errors.",
               requests_sent, bytes_checked, frames_closed, phase_errors_seen);
      $display("Covered a saturated count frame, a long receiver hold-off (%0d full cycles).",
               full_stall_cycles);
      if (error_count == 0) begin
         $display("** command_frame_builder_sum_check_top: PASSED **");
      end else begin
         $display("** command_frame_builder_sum_check_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== command_frame_builder_sum_check_top.f =====
rtl/core/cfb_pkg.sv
rtl/core/cfb_front.sv
rtl/core/cfb_queue.sv
rtl/core/cfb_back.sv
rtl/core/command_frame_builder_sum_check_top.sv
sim/command_frame_builder_sum_check_top_test.sv
